// ===== design/iath_pkg.sv =====
// Shared constants for the inverse hyperbolic tangent unit.
// No dependencies; used by every module of the block.
package iath_pkg;

    localparam int LOG_FRAC = 56;     // fraction bits of the log2 values
    localparam int F_BITS   = 61;     // normalized mantissa, Q1.60 in [1,2)
    localparam int R_BITS   = 61;     // log2 value, exponent over 56 fraction bits
    localparam int K_BITS   = 5;      // exponent of the leading one
    localparam int Y_BITS   = 20;     // result width, Q3.x

    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

    typedef logic [F_BITS-1:0] mant_t;
    typedef logic [R_BITS-1:0] log_t;
    typedef logic [Y_BITS-1:0] y_t;

endpackage

// ===== design/iath_norm.sv =====
// Two-stage normalizer: leading-one search, then shift to a Q1.60 mantissa.
// Depends on iath_pkg.
module iath_norm import iath_pkg::*;
#(
    parameter int IN_BITS = 16
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [IN_BITS-1:0] m,
    output mant_t              f,
    output log_t               r
);

    logic [IN_BITS-1:0] m_reg;
    logic [K_BITS-1:0]  k_reg;
    logic [K_BITS-1:0]  k_next;
    logic [IN_BITS-1:0] m_next;
    mant_t              f_reg;
    log_t               r_reg;

    always_comb
    begin
        m_next = (m == '0) ? IN_BITS'(1) : m;
        k_next = '0;
        for (int i = 0; i < IN_BITS; i++)
        begin
            if (m_next[i])
            begin
                k_next = K_BITS'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
            k_reg <= k_next;
            f_reg <= F_BITS'(m_reg) << (7'd60 - 7'(k_reg));
            r_reg <= R_BITS'(k_reg) << LOG_FRAC;
        end
    end

    assign f = f_reg;
    assign r = r_reg;

endmodule

// ===== design/iath_log_step.sv =====
// One fraction bit of log2: square the mantissa over two stages, renormalize.
// Depends on iath_pkg.
module iath_log_step import iath_pkg::*;
#(
    parameter int BIT = 55
)
(
    input  logic  clk,
    input  logic  en,
    input  mant_t f_in,
    input  log_t  r_in,
    output mant_t f_out,
    output log_t  r_out
);

    logic [63:0]  p00_reg;
    logic [60:0]  p01_reg;
    logic [57:0]  p11_reg;
    log_t         ra_reg;
    logic [121:0] sum;
    logic [61:0]  sq;
    mant_t        f_next;
    log_t         r_next;
    mant_t        f_reg;
    log_t         r_reg;

    // f = a1*2^32 + a0, f^2 = a1^2*2^64 + 2*a0*a1*2^32 + a0^2
    always_comb
    begin
        sum = {p11_reg, 64'd0} + {28'd0, p01_reg, 33'd0} + {58'd0, p00_reg};
        sq  = sum[121:60];
        if (sq[61])
        begin
            f_next = sq[61:1];
            r_next = ra_reg | (R_BITS'(1) << BIT);
        end
        else
        begin
            f_next = sq[60:0];
            r_next = ra_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= 64'(f_in[31:0]) * 64'(f_in[31:0]);
            p01_reg <= 61'(f_in[31:0]) * 61'(f_in[60:32]);
            p11_reg <= 58'(f_in[60:32]) * 58'(f_in[60:32]);
            ra_reg  <= r_in;
            f_reg   <= f_next;
            r_reg   <= r_next;
        end
    end

    assign f_out = f_reg;
    assign r_out = r_reg;

endmodule

// ===== design/iath_scale.sv =====
// Scale by ln2 (partial products, then sum), round, apply sign and saturate.
// Three register stages; the last is the output register. Depends on iath_pkg.
module iath_scale import iath_pkg::*;
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic clk,
    input  logic en,
    input  log_t mag,
    input  logic neg,
    input  logic dom,
    output y_t   y,
    output logic dom_out
);

    localparam int SHIFT = LOG_FRAC + 1 - OUT_FRAC_BITS;
    localparam logic [63:0] RND  = 64'd1 << (SHIFT - 1);
    localparam logic [63:0] YMAX = (64'd1 << (Y_BITS - 1)) - 64'd1;
    localparam logic [63:0] YMIN_MAG = 64'd1 << (Y_BITS - 1);

    logic [63:0]  q00_reg;
    logic [63:0]  q01_reg;
    logic [60:0]  q10_reg;
    logic [60:0]  q11_reg;
    logic         neg1_reg;
    logic         dom1_reg;
    logic [124:0] sum;
    logic [60:0]  hi_reg;
    logic         neg2_reg;
    logic         dom2_reg;
    logic [63:0]  rnd;
    logic [63:0]  negv;
    y_t           y_next;
    y_t           y_reg;
    logic         dom3_reg;

    always_comb
    begin
        sum = {q11_reg, 64'd0} + {29'd0, q01_reg, 32'd0} + {32'd0, q10_reg, 32'd0}
            + {61'd0, q00_reg};
        rnd  = ({3'd0, hi_reg} + RND) >> SHIFT;
        negv = '0;
        if (dom2_reg)
        begin
            y_next = YMIN_MAG[Y_BITS-1:0];
        end
        else if (neg2_reg)
        begin
            negv   = (rnd > YMIN_MAG) ? -YMIN_MAG : -rnd;
            y_next = negv[Y_BITS-1:0];
        end
        else
        begin
            y_next = (rnd > YMAX) ? YMAX[Y_BITS-1:0] : rnd[Y_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q00_reg  <= 64'(mag[31:0]) * 64'(LN2_Q64[31:0]);
            q01_reg  <= 64'(mag[31:0]) * 64'(LN2_Q64[63:32]);
            q10_reg  <= 61'(mag[60:32]) * 61'(LN2_Q64[31:0]);
            q11_reg  <= 61'(mag[60:32]) * 61'(LN2_Q64[63:32]);
            neg1_reg <= neg;
            dom1_reg <= dom;
            hi_reg   <= sum[124:64];
            neg2_reg <= neg1_reg;
            dom2_reg <= dom1_reg;
            y_reg    <= y_next;
            dom3_reg <= dom2_reg;
        end
    end

    assign y       = y_reg;
    assign dom_out = dom3_reg;

endmodule

// ===== design/inverse_hyperbolic_tangent_unit.sv =====
// Top level of the fixed-point atanh unit: input staging, two log2 lanes, scaling.
// Depends on iath_pkg, iath_norm, iath_log_step and iath_scale.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one sample x, signed Q1.(IN_BITS-1).
//   Master stream (m_tvalid/m_tready/m_tdata/m_tuser) returns atanh(x) in signed
//   Q3.OUT_FRAC_BITS (20 bits, rounded to nearest, saturated) and a domain flag in m_tuser,
//   set only for x = -1, where y is the most negative code.
//   Pipeline stages: 1 input stage, 2 normalize stages, 112 log2 stages (56 fraction
//   bits, each one squaring split into a partial-product stage and a sum stage), 1 subtract
//   stage and 3 stages for the ln2 multiply, rounding and saturation.
//   One transaction per cycle when not stalled; both log2 lanes run side by side.
//   The whole pipeline advances together; when m_tvalid is high and m_tready is low every
//   stage holds and s_tready drops, so nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline comes out of reset empty and ready.
module inverse_hyperbolic_tangent_unit import iath_pkg::*;
#(
    parameter int IN_BITS       = 16,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((IN_BITS+7)/8)*8-1:0] s_tdata,  // [IN_BITS-1:0] x
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata,  // [19:0] y
    output logic                         m_tuser   // domain_error
);

    localparam int PRE_LAT = 1 + 2 + 2 * LOG_FRAC + 1;
    localparam int TOTAL   = PRE_LAT + 3;
    localparam logic [IN_BITS:0] HALF = (IN_BITS+1)'(1) << (IN_BITS - 1);

    logic               en;
    logic [TOTAL-1:0]   v_reg;
    logic [PRE_LAT-1:0] dom_reg;
    logic [IN_BITS-1:0] x;
    logic [IN_BITS:0]   xs;
    logic [IN_BITS:0]   n_full;
    logic [IN_BITS:0]   d_full;
    logic [IN_BITS-1:0] n_reg;
    logic [IN_BITS-1:0] d_reg;
    mant_t              fn [0:LOG_FRAC];
    mant_t              fd [0:LOG_FRAC];
    log_t               rn [0:LOG_FRAC];
    log_t               rd [0:LOG_FRAC];
    log_t               mag_reg;
    logic               neg_reg;
    y_t                 y;

    assign en       = !v_reg[TOTAL-1] || m_tready;
    assign s_tready = en;

    assign x      = s_tdata[IN_BITS-1:0];
    assign xs     = {x[IN_BITS-1], x};
    assign n_full = HALF + xs;
    assign d_full = HALF - xs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[TOTAL-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= n_full[IN_BITS-1:0];
            d_reg   <= d_full[IN_BITS-1:0];
            dom_reg <= {dom_reg[PRE_LAT-2:0], (xs == -HALF)};
            neg_reg <= rn[LOG_FRAC] < rd[LOG_FRAC];
            mag_reg <= (rn[LOG_FRAC] < rd[LOG_FRAC]) ? (rd[LOG_FRAC] - rn[LOG_FRAC])
                                                     : (rn[LOG_FRAC] - rd[LOG_FRAC]);
        end
    end

    iath_norm #(.IN_BITS(IN_BITS)) u_norm_n
    (
        .clk (clk),
        .en  (en),
        .m   (n_reg),
        .f   (fn[0]),
        .r   (rn[0])
    );

    iath_norm #(.IN_BITS(IN_BITS)) u_norm_d
    (
        .clk (clk),
        .en  (en),
        .m   (d_reg),
        .f   (fd[0]),
        .r   (rd[0])
    );

    for (genvar j = 0; j < LOG_FRAC; j++)
    begin : g_step
        iath_log_step #(.BIT(LOG_FRAC - 1 - j)) u_step_n
        (
            .clk   (clk),
            .en    (en),
            .f_in  (fn[j]),
            .r_in  (rn[j]),
            .f_out (fn[j+1]),
            .r_out (rn[j+1])
        );

        iath_log_step #(.BIT(LOG_FRAC - 1 - j)) u_step_d
        (
            .clk   (clk),
            .en    (en),
            .f_in  (fd[j]),
            .r_in  (rd[j]),
            .f_out (fd[j+1]),
            .r_out (rd[j+1])
        );
    end

    iath_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale
    (
        .clk     (clk),
        .en      (en),
        .mag     (mag_reg),
        .neg     (neg_reg),
        .dom     (dom_reg[PRE_LAT-1]),
        .y       (y),
        .dom_out (m_tuser)
    );

    assign m_tvalid = v_reg[TOTAL-1];
    assign m_tdata  = {4'd0, y};

endmodule
